>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define SFE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfe assertion failed");

// next-cycle implication
`define SFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfe assertion failed");

`endif

>>> sv/sfe_pkg.sv
package sfe_pkg;

    localparam int TAPS     = 81;
    localparam int BANKS    = 3;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int CSUM_W   = COEF_W + 2;
    localparam int PROD_W   = SAMPLE_W + CSUM_W;
    localparam int ACC_W    = PROD_W + ((TAPS > 1) ? $clog2(TAPS) : 1);
    localparam int CNT_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FRAC_W   = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_ENABLE = 1'd1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    localparam logic [1:0] BANK_LOW  = 2'd0;
    localparam logic [1:0] BANK_BAND = 2'd1;
    localparam logic [1:0] BANK_HIGH = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [CSUM_W-1:0]   csum_t;

    typedef struct packed {
        sample_t lh;
        sample_t rh;
        coef_t   c_low;
        coef_t   c_band;
        coef_t   c_high;
    } sfe_tap_t;

    typedef struct packed {
        logic shift;
        logic rot;
    } sfe_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SAT
    } sfe_state_t;

endpackage

>>> sv/sfe_if.sv
interface sfe_in_if;
    import sfe_pkg::*;
    logic        valid;
    logic        ready;
    logic        kind;
    sample_t     left_in;
    sample_t     right_in;
    logic [1:0]  coef_bank;
    logic [6:0]  coef_tap;
    coef_t       coef_value;

    modport source (output valid, kind, left_in, right_in, coef_bank, coef_tap, coef_value,
                    input ready);
    modport sink (input valid, kind, left_in, right_in, coef_bank, coef_tap, coef_value,
                  output ready);
endinterface

interface sfe_out_if;
    import sfe_pkg::*;
    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink (input valid, left_out, right_out, output ready);
endinterface

>>> sv/sfe_cell.sv
module sfe_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  sfe_pkg::sfe_ctl_t ctl,
    input  sfe_pkg::sfe_tap_t prev,
    input  sfe_pkg::sfe_tap_t next,
    input  logic [2:0]        wr_en,
    input  sfe_pkg::coef_t    wr_val,
    output sfe_pkg::sfe_tap_t q
);
    import sfe_pkg::*;

    sfe_tap_t tap_reg;
    sfe_tap_t tap_next;

    always_comb
    begin
        tap_next = tap_reg;
        if (ctl.rot)
        begin
            tap_next = next;
        end
        else if (ctl.shift)
        begin
            tap_next.lh = prev.lh;
            tap_next.rh = prev.rh;
        end
        else
        begin
            if (wr_en[0]) tap_next.c_low  = wr_val;
            if (wr_en[1]) tap_next.c_band = wr_val;
            if (wr_en[2]) tap_next.c_high = wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else
        begin
            tap_reg <= tap_next;
        end
    end

    assign q = tap_reg;
endmodule

>>> sv/sfe_mac.sv
module sfe_mac (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            mul_en,
    input  sfe_pkg::sample_t sample,
    input  sfe_pkg::csum_t   csum,
    output sfe_pkg::sample_t y
);
    import sfe_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  shifted;

    always_comb
    begin
        acc_next = acc_reg;
        if (start)
        begin
            acc_next = '0;
        end
        else if (pv_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            pv_reg  <= mul_en;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= PROD_W'(sample) * PROD_W'(csum);
        end
    end

    // floor shift then clamp to the sample range
    always_comb
    begin
        shifted = acc_reg >>> FRAC_W;
        if (shifted > ACC_W'(32767))
        begin
            y = 16'sh7FFF;
        end
        else if (shifted < -ACC_W'(32768))
        begin
            y = 16'sh8000;
        end
        else
        begin
            y = shifted[SAMPLE_W-1:0];
        end
    end
endmodule

>>> sv/stereo_fir_band_mixing_equalizer.sv
// Stereo FIR equalizer, TAPS taps per channel with three coefficient banks
// (low, band, high) summed when enabled. Each input item is either a stereo
// sample pair, which yields one result item, or a coefficient write, which
// yields none. Bypass returns the sample in the cycle after it is taken;
// with no bank enabled the result is zero, also in the cycle after. For a
// filtered sample the history and coefficients sit in a ring of cells that
// rotates once per cycle past a single multiply-accumulate per channel,
// then a drain state lets the last product in and a saturate state clamps.
// The block takes a new item only when idle and its result has been taken.
// Configuration: index 0 bypass, index 1 band_enable.
module stereo_fir_band_mixing_equalizer (
    input  logic                             clk,
    input  logic                             rst_n,
    sfe_in_if.sink                           samples,
    sfe_out_if.source                        results,
    input  logic                             cfg_we,
    input  logic [sfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sfe_pkg::*;
    `include "assert_macros.svh"

    // configuration registers
    logic       bypass_reg;
    logic [2:0] band_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg      <= 1'b0;
            band_enable_reg <= 3'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BYPASS:      bypass_reg      <= cfg_data[0];
                CFG_BAND_ENABLE: band_enable_reg <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // sequencer
    sfe_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    sample_t          out_l_reg, out_l_next;
    sample_t          out_r_reg, out_r_next;
    logic             accept;
    logic             start;
    logic             mul_en;
    sfe_ctl_t         ctl;
    sample_t          y_l, y_r;

    // input is taken only when idle with no result waiting
    assign samples.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept = samples.valid && samples.ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        start          = 1'b0;
        mul_en         = 1'b0;
        ctl            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && samples.kind == KIND_SAMPLE)
                begin
                    ctl.shift = 1'b1;
                    if (bypass_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_l_next     = samples.left_in;
                        out_r_next     = samples.right_in;
                    end
                    else if (band_enable_reg == 3'd0)
                    begin
                        // muted
                        out_valid_next = 1'b1;
                        out_l_next     = '0;
                        out_r_next     = '0;
                    end
                    else
                    begin
                        start      = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // one tap per cycle; the ring comes back home after TAPS turns
                ctl.rot = 1'b1;
                mul_en  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last product joins the accumulator
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                out_valid_next = 1'b1;
                out_l_next     = y_l;
                out_r_next     = y_r;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_l_reg <= out_l_next;
        out_r_reg <= out_r_next;
    end

    assign results.valid     = out_valid_reg;
    assign results.left_out  = out_l_reg;
    assign results.right_out = out_r_reg;

    // coefficient write decode: bank three is dropped
    logic [2:0] bank_sel;
    logic       coef_wr;

    assign coef_wr = accept && samples.kind == KIND_COEF;

    always_comb
    begin
        case (samples.coef_bank)
            BANK_LOW:  bank_sel = 3'b001;
            BANK_BAND: bank_sel = 3'b010;
            BANK_HIGH: bank_sel = 3'b100;
            default:   bank_sel = 3'b000;
        endcase
    end

    // ring of tap cells, cell 0 holds the newest sample and feeds the macs
    sfe_tap_t taps [TAPS];
    sfe_tap_t newest;

    always_comb
    begin
        newest    = '0;
        newest.lh = samples.left_in;
        newest.rh = samples.right_in;
    end

    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        logic [2:0] wr_en;
        assign wr_en = (coef_wr && int'(samples.coef_tap) == k) ? bank_sel : 3'b000;

        sfe_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .prev   ((k == 0) ? newest : taps[(k == 0) ? 0 : k - 1]),
            .next   (taps[(k + 1) % TAPS]),
            .wr_en  (wr_en),
            .wr_val (samples.coef_value),
            .q      (taps[k])
        );
    end

    // mixed coefficient of the tap at the head of the ring
    csum_t csum;

    always_comb
    begin
        csum = '0;
        if (band_enable_reg[0]) csum = csum + CSUM_W'(taps[0].c_low);
        if (band_enable_reg[1]) csum = csum + CSUM_W'(taps[0].c_band);
        if (band_enable_reg[2]) csum = csum + CSUM_W'(taps[0].c_high);
    end

    sfe_mac u_mac_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mul_en (mul_en),
        .sample (taps[0].lh),
        .csum   (csum),
        .y      (y_l)
    );

    sfe_mac u_mac_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mul_en (mul_en),
        .sample (taps[0].rh),
        .csum   (csum),
        .y      (y_r)
    );

    `SFE_ASSERT_IMPL(a_accept_idle, accept, state_reg == ST_IDLE)
    `SFE_ASSERT_NEXT(a_run_end, state_reg == ST_RUN && cnt_reg == CNT_W'(TAPS - 1),
                     state_reg == ST_DRAIN)
    `SFE_ASSERT_NEXT(a_sat_out, state_reg == ST_SAT, out_valid_reg && state_reg == ST_IDLE)
    `SFE_ASSERT_IMPL(a_no_take_pending, out_valid_reg, !samples.ready)
endmodule

>>> tb/sv/tb_stereo_fir_band_mixing_equalizer.sv
module tb_stereo_fir_band_mixing_equalizer;
    timeunit 1ns;
    timeprecision 1ps;
    import sfe_pkg::*;

    // equalizer model: histories, coefficient banks and register copies
    class eq_scoreboard;
        sample_t left_hist[TAPS];
        sample_t right_hist[TAPS];
        coef_t   coefs[BANKS][TAPS];
        bit      bypass_on;
        bit [2:0] bands;
        sample_t want_left[$];
        sample_t want_right[$];
        int      errors;
        int      seen;

        function new();
            for (int j = 0; j < TAPS; j++)
            begin
                left_hist[j] = '0;
                right_hist[j] = '0;
                for (int b = 0; b < BANKS; b++)
                    coefs[b][j] = '0;
            end
            bypass_on = 0;
            bands = '0;
            errors = 0;
            seen = 0;
        endfunction

        function sample_t filtered(ref sample_t h[TAPS]);
            longint acc;
            longint c;
            longint q;
            acc = 0;
            for (int j = 0; j < TAPS; j++)
            begin
                c = 0;
                if (bands[0]) c += coefs[BANK_LOW][j];
                if (bands[1]) c += coefs[BANK_BAND][j];
                if (bands[2]) c += coefs[BANK_HIGH][j];
                acc += longint'(h[j]) * c;
            end
            q = acc >>> FRAC_W;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return sample_t'(q);
        endfunction

        function void note_item(logic kind, sample_t l, sample_t r, logic [1:0] bank,
                                logic [6:0] tap, coef_t val);
            if (kind == KIND_COEF)
            begin
                if (bank < BANKS && tap < TAPS)
                    coefs[bank][tap] = val;
                return;
            end
            for (int j = TAPS - 1; j > 0; j--)
            begin
                left_hist[j] = left_hist[j-1];
                right_hist[j] = right_hist[j-1];
            end
            left_hist[0] = l;
            right_hist[0] = r;
            if (bypass_on)
            begin
                want_left.push_back(l);
                want_right.push_back(r);
            end
            else if (bands == 0)
            begin
                want_left.push_back('0);
                want_right.push_back('0);
            end
            else
            begin
                want_left.push_back(filtered(left_hist));
                want_right.push_back(filtered(right_hist));
            end
        endfunction

        function void check_result(sample_t l, sample_t r);
            sample_t el;
            sample_t er;
            seen++;
            if (want_left.size() == 0)
            begin
                $error("unexpected result item left_out=%0d right_out=%0d", l, r);
                errors++;
                return;
            end
            el = want_left.pop_front();
            er = want_right.pop_front();
            if (l !== el)
            begin
                $error("left_out expected %0d actual %0d", el, l);
                errors++;
            end
            if (r !== er)
            begin
                $error("right_out expected %0d actual %0d", er, r);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sfe_in_if samples_ch();
    sfe_out_if results_ch();

    stereo_fir_band_mixing_equalizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_ch.sink),
        .results   (results_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    eq_scoreboard eq = new();
    int cycle_count = 0;
    int hold_off = 0;        // cycles of forced receiver stall, set by the stimulus
    int sample_items = 0;
    int coef_items = 0;

    // drive known values on the input channel from time zero
    initial
    begin
        samples_ch.valid = 0;
        samples_ch.kind = KIND_SAMPLE;
        samples_ch.left_in = '0;
        samples_ch.right_in = '0;
        samples_ch.coef_bank = '0;
        samples_ch.coef_tap = '0;
        samples_ch.coef_value = '0;
        results_ch.ready = 0;
    end

    // random short gaps, sometimes long
    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 300);
    endfunction

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (results_ch.valid && results_ch.ready)
                eq.check_result(results_ch.left_out, results_ch.right_out);
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                results_ch.ready <= 0;
            end
            else
                results_ch.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // record each accepted input item in the model
    always @(posedge clk)
    begin
        if (rst_n && samples_ch.valid && samples_ch.ready)
            eq.note_item(samples_ch.kind, samples_ch.left_in, samples_ch.right_in,
                         samples_ch.coef_bank, samples_ch.coef_tap, samples_ch.coef_value);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2500000)
        begin
            $display("tb_stereo_fir_band_mixing_equalizer NOT OK");
            $finish;
        end
    end

    // offer one item and hold it until accepted; valid stays up for a
    // following item without gap and is dropped by the next gap or idle wait
    task send_item(logic kind, sample_t l, sample_t r, logic [1:0] bank, logic [6:0] tap,
                   coef_t val, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            samples_ch.valid <= 0;
            repeat (g) @(posedge clk);
        end
        samples_ch.valid <= 1;
        samples_ch.kind <= kind;
        samples_ch.left_in <= l;
        samples_ch.right_in <= r;
        samples_ch.coef_bank <= bank;
        samples_ch.coef_tap <= tap;
        samples_ch.coef_value <= val;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        if (kind == KIND_SAMPLE) sample_items++;
        else coef_items++;
    endtask

    task send_sample(sample_t l, sample_t r);
        send_item(KIND_SAMPLE, l, r, '0, '0, '0, 0);
    endtask

    task send_coef(logic [1:0] bank, logic [6:0] tap, coef_t val);
        send_item(KIND_COEF, sample_t'($urandom), sample_t'($urandom), bank, tap, val, 0);
    endtask

    // stop offering, settle until every expected result is back, then let the block go idle
    task wait_idle();
        samples_ch.valid <= 0;
        @(posedge clk);
        while (eq.want_left.size() != 0) @(posedge clk);
        repeat (TAPS + 10) @(posedge clk);
    endtask

    // registers change only while the block is idle
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == CFG_BYPASS) eq.bypass_on = val[0];
        else eq.bands = val[2:0];
    endtask

    function sample_t rand_sample();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 16'sh7fff;
        if (p == 1) return 16'sh8000;
        return sample_t'($urandom);
    endfunction

    initial
    begin
        logic [1:0] bank;
        logic [6:0] tap;
        int p;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: muted after reset, bypass, extremes, ignored writes, saturation
        send_sample(16'sh7fff, 16'sh8000);
        write_reg(CFG_BYPASS, 3'd1);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh0001, -16'sh0001);
        write_reg(CFG_BYPASS, 3'd0);
        write_reg(CFG_BAND_ENABLE, 3'd7);
        send_coef(BANK_LOW, 7'd0, 16'sh7fff);
        send_coef(BANK_BAND, 7'd0, 16'sh7fff);
        send_coef(BANK_HIGH, 7'd0, 16'sh7fff);
        send_coef(BANK_HIGH, 7'(TAPS - 1), 16'sh8000);
        send_coef(2'd3, 7'd1, 16'sh7fff);        // bank three is dropped
        send_coef(BANK_LOW, 7'd81, 16'sh7fff);   // tap out of range
        send_coef(BANK_LOW, 7'd127, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000);       // saturates both ways
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh0000, 16'sh0000);
        write_reg(CFG_BAND_ENABLE, 3'd1);
        send_sample(16'sh4000, -16'sh4000);
        write_reg(CFG_BAND_ENABLE, 3'd0);
        send_sample(16'sh1234, 16'sh5678);

        // long receiver hold-off while the sender keeps offering
        write_reg(CFG_BAND_ENABLE, 3'd7);
        hold_off = 400;
        for (int i = 0; i < 6; i++)
            send_item(KIND_SAMPLE, rand_sample(), rand_sample(), '0, '0, '0, 1);

        // random phases over the register settings
        for (int ph = 0; ph < 14; ph++)
        begin
            write_reg(CFG_BYPASS, (ph % 5 == 4) ? 3'd1 : 3'd0);
            write_reg(CFG_BAND_ENABLE, (ph < 8) ? ph[2:0] : 3'($urandom_range(1, 7)));
            for (int i = 0; i < 100; i++)
            begin
                p = $urandom_range(0, 99);
                if (p < 25)
                begin
                    bank = (p < 2) ? 2'd3 : 2'($urandom_range(0, 2));
                    tap = (p < 4) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, TAPS - 1));
                    send_coef(bank, tap, (p < 8) ? rand_sample() : coef_t'($urandom_range(0, 8191) - 4096));
                end
                else
                    send_sample(rand_sample(), rand_sample());
            end
        end

        wait_idle();
        repeat (2 * TAPS + 20) @(posedge clk);
        $display("covered %0d sample items and %0d coefficient writes, %0d results checked",
                 sample_items, coef_items, eq.seen);
        $display("register settings: bypass on/off, every band_enable mix incl. mute");
        if (eq.errors == 0 && eq.want_left.size() == 0)
            $display("tb_stereo_fir_band_mixing_equalizer OK");
        else
            $display("tb_stereo_fir_band_mixing_equalizer NOT OK");
        $finish;
    end
endmodule
